// ===== rtl/core/mlp_pkg.sv =====
// Shared types, codes and arithmetic helpers for the perceptron engine.
// Pure package: no dependencies. Used by the top level, interfaces' users
// and the port checker.
`default_nettype none
package mlp_pkg;

  // Request function codes
  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_FEAT  = 3'd2,
    FN_TGT   = 3'd3,
    FN_RUN   = 3'd4
  } func_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_LAYERS = 3'd0,
    REG_IN_W   = 3'd1,
    REG_HID_A  = 3'd2,
    REG_HID_B  = 3'd3,
    REG_OUT_W  = 3'd4,
    REG_LRATE  = 3'd5
  } reg_idx_t;

  localparam int CFG_AW = 5;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_RD_WAIT,
    ST_F_ADDR,
    ST_F_MUL,
    ST_F_ACC,
    ST_F_DONE,
    ST_F_IDX,
    ST_F_SIG,
    ST_F_EMIT,
    ST_B_OADDR,
    ST_B_OWR,
    ST_B_HINIT,
    ST_B_HADDR,
    ST_B_HMUL,
    ST_B_HACC,
    ST_B_HS,
    ST_B_HD1,
    ST_B_HD2,
    ST_B_HD3,
    ST_B_HD4,
    ST_U_EADDR,
    ST_U_E,
    ST_U_LE,
    ST_U_ADDR,
    ST_U_MUL,
    ST_U_WR
  } st_t;

  // Round to nearest (ties up) dropping 12 fraction bits
  function automatic logic signed [49:0] rnd12(input logic signed [49:0] x);
    return (x + 50'sd2048) >>> 12;
  endfunction

  // Round to nearest (ties up) dropping 24 fraction bits
  function automatic logic signed [49:0] rnd24(input logic signed [49:0] x);
    return (x + (50'sd1 <<< 23)) >>> 24;
  endfunction

  // Saturate to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
    if (x > 50'sd32767) return 16'sh7fff;
    if (x < -50'sd32768) return 16'sh8000;
    return 16'(x);
  endfunction

  // Clamp a layer width to 1..m
  function automatic logic [3:0] clamp_w(input logic [3:0] w, input logic [3:0] m);
    if (w < 4'd1) return 4'd1;
    if (w > m) return m;
    return w;
  endfunction

  // Shift-subtract division, elaboration use only (table build)
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at the center of cell i of n cells over [-8,8), Q4.12
  function automatic logic signed [15:0] sig_entry(input int i, input int n);
    logic signed [63:0] xq;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] a4;
    logic [63:0] y;
    logic [63:0] den;
    logic [63:0] q;
    xq = -(64'sd8 <<< 30) +
         signed'(udiv(64'(2 * i + 1) * (64'd8 << 30), 64'(n)));
    t = (xq < 0) ? 64'(-xq) : 64'(xq);
    a = t >> 8;
    a2 = (a * a) >> 30;
    a3 = (a2 * a) >> 30;
    a4 = (a3 * a) >> 30;
    y = (64'd1 << 30) - a + (a2 >> 1) - a3 / 6 + a4 / 24;
    for (int k = 0; k < 8; k++) y = (y * y) >> 30;
    den = (64'd1 << 30) + y;
    q = udiv((64'd1 << 42) + (den >> 1), den);
    return (xq >= 0) ? 16'(q) : 16'(64'd4096 - q);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mlp_in_if.sv =====
// Request channel: valid/ready plus request payload.
// No dependencies.
`default_nettype none
interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [7:0]         position;
  logic signed [15:0] value;
  logic               train;

  modport source(output valid, func, position, value, train, input ready);
  modport sink(input valid, func, position, value, train, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mlp_out_if.sv =====
// Result channel: valid/ready plus result payload.
// No dependencies.
`default_nettype none
interface mlp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic [2:0]         neuron_number;
  logic               last;

  modport source(output valid, result_value, neuron_number, last, input ready);
  modport sink(input valid, result_value, neuron_number, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mlp_forward_backprop_step.sv =====
// Perceptron engine: 2..4 layers, Q4.12, forward pass and one SGD step.
// Weight write, feature/target set: done as the request is taken. Weight read: the
// result is registered via ST_RD_DATA. Run: forward pass over each weight and bias,
// sigmoid per hidden and emit per output neuron (waits for out-ready); training adds
// output and hidden errors and the weight and bias update; all on one multiplier.
// Sync active-low reset clears control and config; memories hold no reset value.
`default_nettype none
module mlp_forward_backprop_step
  import mlp_pkg::*;
#(
  parameter int MAX_LAYERS      = 4,
  parameter int MAX_WIDTH       = 8,
  parameter int WEIGHT_DEPTH    = 256,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mlp_in_if.sink                 in_ch,
  mlp_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int NDEPTH = MAX_LAYERS * MAX_WIDTH;
  localparam int NA     = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
  localparam int TA     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WA     = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int PW     = (WA > 8) ? WA : 8;
  localparam int SA     = $clog2(SIGMOID_ENTRIES);
  localparam int PRW    = 17 + SA;
  localparam int LIM    = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam logic [3:0] WMAX = (MAX_WIDTH < 8) ? 4'(MAX_WIDTH) : 4'd8;

  // Neuron slot = layer * MAX_WIDTH + neuron
  function automatic logic [NA-1:0] slot(input logic [1:0] l, input logic [3:0] k);
    logic [15:0] w;
    w = 16'(l) * 16'(MAX_WIDTH) + 16'(k);
    return NA'(w);
  endfunction

  function automatic logic [WA-1:0] waddr(input logic [7:0] i);
    logic [PW-1:0] e;
    e = PW'(i);
    return WA'(e);
  endfunction

  // ---------------- configuration registers ----------------
  logic [2:0]  layer_count_r;
  logic [3:0]  input_width_r, hidden_width_a_r, hidden_width_b_r, output_width_r;
  logic [12:0] learning_rate_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r    <= 3'd3;
      input_width_r    <= 4'd2;
      hidden_width_a_r <= 4'd4;
      hidden_width_b_r <= 4'd4;
      output_width_r   <= 4'd1;
      learning_rate_r  <= 13'd410;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_LAYERS: layer_count_r    <= pwdata[2:0];
        REG_IN_W:   input_width_r    <= pwdata[3:0];
        REG_HID_A:  hidden_width_a_r <= pwdata[3:0];
        REG_HID_B:  hidden_width_b_r <= pwdata[3:0];
        REG_OUT_W:  output_width_r   <= pwdata[3:0];
        REG_LRATE:  learning_rate_r  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_LAYERS: prdata = {29'd0, layer_count_r};
      REG_IN_W:   prdata = {28'd0, input_width_r};
      REG_HID_A:  prdata = {28'd0, hidden_width_a_r};
      REG_HID_B:  prdata = {28'd0, hidden_width_b_r};
      REG_OUT_W:  prdata = {28'd0, output_width_r};
      REG_LRATE:  prdata = {19'd0, learning_rate_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------- network layout ----------------
  logic [2:0] nl;
  logic [1:0] ol;
  logic [3:0] sz [4];
  logic [7:0] wb2, wb3;

  always_comb begin
    if (layer_count_r < 3'd2)           nl = 3'd2;
    else if (layer_count_r > 3'(LIM))   nl = 3'(LIM);
    else                                nl = layer_count_r;
    ol = 2'(nl - 3'd1);
    for (int i = 0; i < 4; i++) sz[i] = 4'd1;
    sz[0] = clamp_w(input_width_r, WMAX);
    if (nl >= 3'd3) sz[1] = clamp_w(hidden_width_a_r, WMAX);
    if (nl == 3'd4) sz[2] = clamp_w(hidden_width_b_r, WMAX);
    sz[ol] = clamp_w(output_width_r, WMAX);
    wb2 = 8'(({4'd0, sz[0]} + 8'd1) * {4'd0, sz[1]});
    wb3 = wb2 + 8'(({4'd0, sz[1]} + 8'd1) * {4'd0, sz[2]});
  end

  // ---------------- sigmoid table ----------------
  logic signed [15:0] sig_rom [SIGMOID_ENTRIES];
  for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_sig
    localparam logic signed [15:0] SigV = sig_entry(gi, SIGMOID_ENTRIES);
    assign sig_rom[gi] = SigV;
  end

  // ---------------- memories ----------------
  logic signed [15:0] wmem [WEIGHT_DEPTH];
  logic signed [15:0] vmem [NDEPTH];
  logic signed [15:0] emem [NDEPTH];
  logic signed [15:0] tmem [MAX_WIDTH];

  logic               wt_we, wt_re, val_we, val_re, err_we, err_re, tgt_we, tgt_re;
  logic [7:0]         wt_widx, wt_ridx;
  logic signed [15:0] wt_wdata, val_wdata, err_wdata, tgt_wdata;
  logic [NA-1:0]      val_wslot, val_rslot, err_wslot, err_rslot;
  logic [TA-1:0]      tgt_widx, tgt_ridx;

  logic signed [15:0] wt_q_r, val_q_r, err_q_r, tgt_q_r;
  logic               wt_ok_r;
  logic signed [15:0] wt_val;

  always_ff @(posedge clk) begin
    if (wt_we && (32'(wt_widx) < 32'(WEIGHT_DEPTH))) wmem[waddr(wt_widx)] <= wt_wdata;
    if (wt_re) begin
      wt_q_r  <= wmem[waddr(wt_ridx)];
      wt_ok_r <= 32'(wt_ridx) < 32'(WEIGHT_DEPTH);
    end
    if (val_we) vmem[val_wslot] <= val_wdata;
    if (val_re) val_q_r <= vmem[val_rslot];
    if (err_we) emem[err_wslot] <= err_wdata;
    if (err_re) err_q_r <= emem[err_rslot];
    if (tgt_we) tmem[tgt_widx] <= tgt_wdata;
    if (tgt_re) tgt_q_r <= tmem[tgt_ridx];
  end

  // Out-of-range weight reads as zero
  assign wt_val = wt_ok_r ? wt_q_r : 16'sd0;

  // ---------------- shared multiplier ----------------
  logic signed [29:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [49:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // ---------------- sequencer ----------------
  st_t                state_r, state_nxt;
  logic [1:0]         lyr_r, lyr_nxt;
  logic [2:0]         nj_r, nj_nxt;
  logic [3:0]         nk_r, nk_nxt;
  logic [7:0]         wp_r, wp_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [49:0] mp_r, mp_nxt;
  logic signed [15:0] s_r, s_nxt;
  logic signed [19:0] d_r, d_nxt;
  logic signed [28:0] le_r, le_nxt;
  logic [SA-1:0]      idx_r, idx_nxt;
  logic               train_r, train_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_value_r, out_value_nxt;
  logic [2:0]         out_num_r, out_num_nxt;
  logic               out_last_r, out_last_nxt;

  logic signed [15:0] s_acc;
  logic [15:0]        sig_u;
  logic [PRW-1:0]     sig_prod;
  logic [3:0]         n_src;
  logic               nj_end;

  assign s_acc    = sat16(rnd12(50'(acc_r)));
  assign sig_u    = {~s_r[15], s_r[14:0]};
  assign sig_prod = PRW'(sig_u) * PRW'(SIGMOID_ENTRIES);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_value  = out_value_r;
  assign out_ch.neuron_number = out_num_r;
  assign out_ch.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lyr_r       <= '0;
      nj_r        <= '0;
      nk_r        <= '0;
      wp_r        <= '0;
      train_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lyr_r       <= lyr_nxt;
      nj_r        <= nj_nxt;
      nk_r        <= nk_nxt;
      wp_r        <= wp_nxt;
      train_r     <= train_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    mp_r        <= mp_nxt;
    s_r         <= s_nxt;
    d_r         <= d_nxt;
    le_r        <= le_nxt;
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
    out_num_r   <= out_num_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Next state, memory control and multiplier operands
  always_comb begin
    state_nxt     = state_r;
    lyr_nxt       = lyr_r;
    nj_nxt        = nj_r;
    nk_nxt        = nk_r;
    wp_nxt        = wp_r;
    acc_nxt       = acc_r;
    mp_nxt        = mp_r;
    s_nxt         = s_r;
    d_nxt         = d_r;
    le_nxt        = le_r;
    idx_nxt       = idx_r;
    train_nxt     = train_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;

    in_ch.ready = 1'b0;
    wt_we = 1'b0;  wt_re = 1'b0;  wt_widx = wp_r;  wt_ridx = wp_r;  wt_wdata = '0;
    val_we = 1'b0; val_re = 1'b0; val_wslot = '0; val_rslot = '0; val_wdata = s_acc;
    err_we = 1'b0; err_re = 1'b0; err_wslot = '0; err_rslot = '0; err_wdata = '0;
    tgt_we = 1'b0; tgt_re = 1'b0; tgt_widx = '0; tgt_ridx = TA'(nj_r);
    tgt_wdata = in_ch.value;
    mul_a = '0;
    mul_b = '0;

    n_src  = sz[2'(lyr_r - 2'd1)];
    nj_end = {1'b0, nj_r} == (sz[lyr_r] - 4'd1);

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (func_t'(in_ch.func))
            FN_WRITE: begin
              wt_we    = 1'b1;
              wt_widx  = in_ch.position;
              wt_wdata = in_ch.value;
            end
            FN_READ: begin
              wt_re     = 1'b1;
              wt_ridx   = in_ch.position;
              state_nxt = ST_RD_DATA;
            end
            FN_FEAT: begin
              if ({4'd0, sz[0]} > in_ch.position) begin
                val_we    = 1'b1;
                val_wslot = slot(2'd0, in_ch.position[3:0]);
                val_wdata = in_ch.value;
              end
            end
            FN_TGT: begin
              if ({4'd0, sz[ol]} > in_ch.position) begin
                tgt_we   = 1'b1;
                tgt_widx = TA'(in_ch.position);
              end
            end
            FN_RUN: begin
              lyr_nxt   = 2'd1;
              nj_nxt    = '0;
              nk_nxt    = '0;
              wp_nxt    = '0;
              acc_nxt   = '0;
              train_nxt = in_ch.train;
              state_nxt = ST_F_ADDR;
            end
            default: ;
          endcase
        end
      end

      // Weight read result
      ST_RD_DATA: begin
        out_value_nxt = wt_val;
        out_num_nxt   = '0;
        out_last_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      // Forward pass: one weight (or the bias) at a time through ADDR, MUL and ACC
      ST_F_ADDR: begin
        wt_re     = 1'b1;
        val_re    = 1'b1;
        val_rslot = slot(2'(lyr_r - 2'd1), nk_r);
        state_nxt = ST_F_MUL;
      end
      ST_F_MUL: begin
        mul_a     = 30'(wt_val);
        mul_b     = (nk_r == n_src) ? 20'sd4096 : 20'(val_q_r);
        mp_nxt    = mul_p;
        state_nxt = ST_F_ACC;
      end
      ST_F_ACC: begin
        acc_nxt = acc_r + signed'(mp_r[39:0]);
        wp_nxt  = wp_r + 8'd1;
        if (nk_r == n_src) begin
          state_nxt = ST_F_DONE;
        end else begin
          nk_nxt    = nk_r + 4'd1;
          state_nxt = ST_F_ADDR;
        end
      end
      ST_F_DONE: begin
        s_nxt = s_acc;
        if (lyr_r == ol) begin
          val_we        = 1'b1;
          val_wslot     = slot(lyr_r, {1'b0, nj_r});
          val_wdata     = s_acc;
          out_value_nxt = s_acc;
          out_num_nxt   = nj_r;
          out_last_nxt  = nj_end;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_F_EMIT;
        end else begin
          state_nxt = ST_F_IDX;
        end
      end
      ST_F_IDX: begin
        idx_nxt   = SA'(sig_prod >> 16);
        state_nxt = ST_F_SIG;
      end
      ST_F_SIG: begin
        val_we    = 1'b1;
        val_wslot = slot(lyr_r, {1'b0, nj_r});
        val_wdata = sig_rom[idx_r];
        nk_nxt    = '0;
        acc_nxt   = '0;
        if (nj_end) begin
          lyr_nxt = lyr_r + 2'd1;
          nj_nxt  = '0;
        end else begin
          nj_nxt = nj_r + 3'd1;
        end
        state_nxt = ST_F_ADDR;
      end
      ST_F_EMIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          nk_nxt        = '0;
          acc_nxt       = '0;
          if (nj_end) begin
            nj_nxt    = '0;
            state_nxt = train_r ? ST_B_OADDR : ST_IDLE;
          end else begin
            nj_nxt    = nj_r + 3'd1;
            state_nxt = ST_F_ADDR;
          end
        end
      end

      // Output error: y - t
      ST_B_OADDR: begin
        val_re    = 1'b1;
        val_rslot = slot(ol, {1'b0, nj_r});
        tgt_re    = 1'b1;
        tgt_ridx  = TA'(nj_r);
        state_nxt = ST_B_OWR;
      end
      ST_B_OWR: begin
        err_we    = 1'b1;
        err_wslot = slot(ol, {1'b0, nj_r});
        err_wdata = sat16(50'(val_q_r) - 50'(tgt_q_r));
        if ({1'b0, nj_r} == (sz[ol] - 4'd1)) begin
          nj_nxt = '0;
          if (ol == 2'd1) begin
            lyr_nxt   = 2'd1;
            nk_nxt    = '0;
            wp_nxt    = '0;
            state_nxt = ST_U_EADDR;
          end else begin
            lyr_nxt   = ol - 2'd1;
            state_nxt = ST_B_HINIT;
          end
        end else begin
          nj_nxt    = nj_r + 3'd1;
          state_nxt = ST_B_OADDR;
        end
      end

      // Hidden error: y(1-y) * sum(w * next error)
      ST_B_HINIT: begin
        wp_nxt    = ((lyr_r == 2'd1) ? wb2 : wb3) + {5'd0, nj_r};
        nk_nxt    = '0;
        acc_nxt   = '0;
        state_nxt = ST_B_HADDR;
      end
      ST_B_HADDR: begin
        wt_re     = 1'b1;
        err_re    = 1'b1;
        err_rslot = slot(2'(lyr_r + 2'd1), nk_r);
        state_nxt = ST_B_HMUL;
      end
      ST_B_HMUL: begin
        mul_a     = 30'(wt_val);
        mul_b     = 20'(err_q_r);
        mp_nxt    = mul_p;
        state_nxt = ST_B_HACC;
      end
      ST_B_HACC: begin
        acc_nxt = acc_r + signed'(mp_r[39:0]);
        if (nk_r == (sz[2'(lyr_r + 2'd1)] - 4'd1)) begin
          state_nxt = ST_B_HS;
        end else begin
          nk_nxt    = nk_r + 4'd1;
          wp_nxt    = wp_r + {4'd0, sz[lyr_r]} + 8'd1;
          state_nxt = ST_B_HADDR;
        end
      end
      ST_B_HS: begin
        s_nxt     = s_acc;
        val_re    = 1'b1;
        val_rslot = slot(lyr_r, {1'b0, nj_r});
        state_nxt = ST_B_HD1;
      end
      ST_B_HD1: begin
        mul_a     = 30'(val_q_r);
        mul_b     = 20'sd4096 - 20'(val_q_r);
        mp_nxt    = mul_p;
        state_nxt = ST_B_HD2;
      end
      ST_B_HD2: begin
        d_nxt     = 20'(rnd12(mp_r));
        state_nxt = ST_B_HD3;
      end
      ST_B_HD3: begin
        mul_a     = 30'(d_r);
        mul_b     = 20'(s_r);
        mp_nxt    = mul_p;
        state_nxt = ST_B_HD4;
      end
      ST_B_HD4: begin
        err_we    = 1'b1;
        err_wslot = slot(lyr_r, {1'b0, nj_r});
        err_wdata = sat16(rnd12(mp_r));
        if (nj_end) begin
          nj_nxt = '0;
          if (lyr_r == 2'd1) begin
            nk_nxt    = '0;
            wp_nxt    = '0;
            state_nxt = ST_U_EADDR;
          end else begin
            lyr_nxt   = lyr_r - 2'd1;
            state_nxt = ST_B_HINIT;
          end
        end else begin
          nj_nxt    = nj_r + 3'd1;
          state_nxt = ST_B_HINIT;
        end
      end

      // Update: w -= rate * e * v, bias -= rate * e
      ST_U_EADDR: begin
        err_re    = 1'b1;
        err_rslot = slot(lyr_r, {1'b0, nj_r});
        state_nxt = ST_U_E;
      end
      ST_U_E: begin
        mul_a     = 30'(signed'({1'b0, learning_rate_r}));
        mul_b     = 20'(err_q_r);
        mp_nxt    = mul_p;
        state_nxt = ST_U_LE;
      end
      ST_U_LE: begin
        le_nxt    = 29'(mp_r);
        state_nxt = ST_U_ADDR;
      end
      ST_U_ADDR: begin
        wt_re     = 1'b1;
        val_re    = 1'b1;
        val_rslot = slot(2'(lyr_r - 2'd1), nk_r);
        state_nxt = ST_U_MUL;
      end
      ST_U_MUL: begin
        mul_a     = 30'(le_r);
        mul_b     = (nk_r == n_src) ? 20'sd4096 : 20'(val_q_r);
        mp_nxt    = mul_p;
        state_nxt = ST_U_WR;
      end
      ST_U_WR: begin
        wt_we    = 1'b1;
        wt_widx  = wp_r;
        wt_wdata = sat16(50'(wt_val) - rnd24(mp_r));
        wp_nxt   = wp_r + 8'd1;
        if (nk_r == n_src) begin
          nk_nxt = '0;
          if (nj_end) begin
            nj_nxt = '0;
            if (lyr_r == ol) begin
              state_nxt = ST_IDLE;
            end else begin
              lyr_nxt   = lyr_r + 2'd1;
              state_nxt = ST_U_EADDR;
            end
          end else begin
            nj_nxt    = nj_r + 3'd1;
            state_nxt = ST_U_EADDR;
          end
        end else begin
          nk_nxt    = nk_r + 4'd1;
          state_nxt = ST_U_ADDR;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/mlp_checker.sv =====
// Port-level checker for the perceptron engine, bound to the top level.
// Depends on mlp_pkg for the request codes.
`default_nettype none
module mlp_checker
  import mlp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_value
);

  // Block never takes a request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  // Weight read result is raised by ST_RD_DATA after the request is taken
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FN_READ) |-> ##2 out_valid)
    else $error("weight read result late");

  // Requests without results leave the block ready again in the cycle after
  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func != FN_READ && in_func != FN_RUN) |=> in_ready)
    else $error("single-cycle request did not return to ready");

  // Stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed");

endmodule

bind mlp_forward_backprop_step mlp_checker u_mlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.result_value)
);
`default_nettype wire

// ===== test/mlp_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the perceptron engine: tracks register writes and requests,
// predicts every result and compares it with what the block returns.
// Depends on mlp_pkg, mlp_in_if and mlp_out_if.
module mlp_result_checker
  import mlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mlp_in_if                 in_mon,
  mlp_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending,
  output int                result_count
);

  typedef struct packed {
    logic signed [15:0] val;
    logic [2:0]         idx;
    logic               last;
  } outcome_t;

  outcome_t expected_q[$];

  // Mirror of the network state
  logic signed [15:0] sig_lut[256];
  logic signed [15:0] wt[256];
  logic signed [15:0] nval[32];
  logic signed [15:0] nerr[32];
  logic signed [15:0] tgt[8];

  // Mirror of the registers
  logic [2:0]  r_layers;
  logic [3:0]  r_inw, r_ha, r_hb, r_outw;
  logic [12:0] r_lrate;

  function automatic longint rnd(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic int clw(logic [3:0] w);
    if (w < 1) return 1;
    if (w > 8) return 8;
    return int'(w);
  endfunction

  function automatic longint wget(int i);
    return (i < 256) ? longint'(wt[i]) : 0;
  endfunction

  // Sigmoid at the middle of cell i: exp by Taylor series then repeated squaring
  function automatic logic signed [15:0] sig_cell(int i);
    longint xq;
    longint unsigned t, a, a2, a3, a4, y, den, q;
    xq = -(64'sd8 <<< 30) + (longint'(2 * i + 1) * (64'sd8 <<< 30)) / 256;
    t = (xq < 0) ? -xq : xq;
    a = t >> 8;
    a2 = (a * a) >> 30;
    a3 = (a2 * a) >> 30;
    a4 = (a3 * a) >> 30;
    y = (64'd1 << 30) - a + (a2 >> 1) - a3 / 6 + a4 / 24;
    for (int k = 0; k < 8; k++) y = (y * y) >> 30;
    den = (64'd1 << 30) + y;
    q = ((64'd1 << 42) + den / 2) / den;
    return (xq >= 0) ? 16'(q) : 16'(64'd4096 - q);
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) sig_lut[i] = sig_cell(i);
  end

  // Forward pass, results, then the optional SGD step
  task automatic do_run(logic train);
    int sz[4];
    int wb[5];
    int nl, base, ol;
    longint acc, s, y, d, e, v, lr;
    outcome_t o;
    sz = '{1, 1, 1, 1};
    wb = '{0, 0, 0, 0, 0};
    nl = (r_layers < 2) ? 2 : ((r_layers > 4) ? 4 : int'(r_layers));
    sz[0] = clw(r_inw);
    if (nl >= 3) sz[1] = clw(r_ha);
    if (nl == 4) sz[2] = clw(r_hb);
    sz[nl-1] = clw(r_outw);
    for (int l = 1; l < nl; l++) wb[l+1] = wb[l] + (sz[l-1] + 1) * sz[l];

    for (int l = 1; l < nl; l++) begin
      for (int j = 0; j < sz[l]; j++) begin
        base = wb[l] + j * (sz[l-1] + 1);
        acc = wget(base + sz[l-1]) * 4096;
        for (int k = 0; k < sz[l-1]; k++)
          acc += longint'(nval[(l-1)*8 + k]) * wget(base + k);
        s = sat(rnd(acc, 12));
        if (l < nl - 1) s = sig_lut[(s + 32768) >> 8];
        nval[l*8 + j] = 16'(s);
      end
    end

    ol = (nl - 1) * 8;
    for (int j = 0; j < sz[nl-1]; j++) begin
      o.val = nval[ol + j];
      o.idx = 3'(j);
      o.last = (j == sz[nl-1] - 1);
      expected_q.push_back(o);
    end
    if (!train) return;

    // Errors, all from the weights before the update
    for (int j = 0; j < sz[nl-1]; j++)
      nerr[ol + j] = 16'(sat(longint'(nval[ol + j]) - longint'(tgt[j])));
    for (int l = nl - 2; l >= 1; l--) begin
      for (int j = 0; j < sz[l]; j++) begin
        acc = 0;
        for (int k = 0; k < sz[l+1]; k++)
          acc += wget(wb[l+1] + k * (sz[l] + 1) + j) * longint'(nerr[(l+1)*8 + k]);
        s = sat(rnd(acc, 12));
        y = nval[l*8 + j];
        d = rnd(y * (4096 - y), 12);
        nerr[l*8 + j] = 16'(sat(rnd(s * d, 12)));
      end
    end

    // Weight and bias update
    lr = longint'(r_lrate);
    for (int l = 1; l < nl; l++) begin
      for (int j = 0; j < sz[l]; j++) begin
        base = wb[l] + j * (sz[l-1] + 1);
        e = nerr[l*8 + j];
        for (int k = 0; k < sz[l-1]; k++) begin
          v = nval[(l-1)*8 + k];
          wt[base + k] = 16'(sat(wget(base + k) - rnd(lr * e * v, 24)));
        end
        wt[base + sz[l-1]] = 16'(sat(wget(base + sz[l-1]) - rnd(lr * e, 12)));
      end
    end
  endtask

  task automatic apply_request(logic [2:0] fn, logic [7:0] pos, logic signed [15:0] val,
                               logic train);
    outcome_t o;
    int inw, outw;
    inw = clw(r_inw);
    outw = clw(r_outw);
    case (fn)
      FN_WRITE: wt[pos] = val;
      FN_READ: begin
        o.val = wt[pos];
        o.idx = '0;
        o.last = 1'b1;
        expected_q.push_back(o);
      end
      FN_FEAT: if (pos < inw) nval[pos] = val;
      FN_TGT:  if (pos < outw) tgt[pos] = val;
      FN_RUN:  do_run(train);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst_n) begin
      r_layers = 3'd3;
      r_inw = 4'd2;
      r_ha = 4'd4;
      r_hb = 4'd4;
      r_outw = 4'd1;
      r_lrate = 13'd410;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      // Returned result against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: value %0d", out_mon.result_value);
          fail_count++;
        end else begin
          exp_o = expected_q.pop_front();
          if (out_mon.result_value !== exp_o.val) begin
            $error("result_value: expected %0d, got %0d", exp_o.val, out_mon.result_value);
            fail_count++;
          end
          if (out_mon.neuron_number !== exp_o.idx) begin
            $error("neuron_number: expected %0d, got %0d", exp_o.idx, out_mon.neuron_number);
            fail_count++;
          end
          if (out_mon.last !== exp_o.last) begin
            $error("last: expected %0d, got %0d", exp_o.last, out_mon.last);
            fail_count++;
          end
        end
      end
      // Register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr >> 2))
          REG_LAYERS: r_layers = pwdata[2:0];
          REG_IN_W:   r_inw = pwdata[3:0];
          REG_HID_A:  r_ha = pwdata[3:0];
          REG_HID_B:  r_hb = pwdata[3:0];
          REG_OUT_W:  r_outw = pwdata[3:0];
          REG_LRATE:  r_lrate = pwdata[12:0];
          default: ;
        endcase
      end
      // Accepted request
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.func, in_mon.position, in_mon.value, in_mon.train);
    end
    pending = expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the perceptron engine testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on mlp_pkg, both
// channel interfaces, mlp_result_checker and the block itself.
module tb;
  import mlp_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count, pending, result_count;
  int                request_count;
  int                seen_results, out_hold;
  logic              no_idle;

  mlp_in_if  in_ch();
  mlp_out_if out_ch();

  mlp_forward_backprop_step dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  mlp_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result back-pressure: a fresh stall length after each returned result
  always @(negedge clk) begin
    if (result_count != seen_results) begin
      seen_results = result_count;
      out_hold = no_idle ? 0 : $urandom_range(0, 4);
    end
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  // One request; called and returns just after a falling edge
  task automatic send_request(func_t fn, logic [7:0] pos, logic signed [15:0] val,
                              logic train);
    int gap;
    logic acc;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.position <= pos;
    in_ch.value <= val;
    in_ch.train <= train;
    acc = 1'b0;
    while (!acc) begin
      #1 acc = in_ch.ready;
      @(negedge clk);
    end
    request_count++;
  endtask

  // Let the block drain, including the tail of a training step
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(int lay, int inw, int ha, int hb, int outw, int lr);
    drain();
    reg_write(REG_LAYERS, lay);
    reg_write(REG_IN_W, inw);
    reg_write(REG_HID_A, ha);
    reg_write(REG_HID_B, hb);
    reg_write(REG_OUT_W, outw);
    reg_write(REG_LRATE, lr);
  endtask

  // Mostly modest Q4.12 values, sometimes the full range
  function automatic logic signed [15:0] pick_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16383)) - 16'sd8192;
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 7));
  endfunction

  task automatic random_request();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 20)      send_request(FN_WRITE, 8'($urandom), pick_value(), 1'($urandom));
    else if (kind < 32) send_request(FN_READ, 8'($urandom), 16'($urandom), 1'($urandom));
    else if (kind < 47) send_request(FN_FEAT, pick_slot(), pick_value(), 1'($urandom));
    else if (kind < 57) send_request(FN_TGT, pick_slot(), pick_value(), 1'($urandom));
    else if (kind < 92) send_request(FN_RUN, 8'($urandom), 16'($urandom), 1'($urandom));
    else send_request(func_t'($urandom_range(5, 7)), 8'($urandom), 16'($urandom),
                      1'($urandom));
  endtask

  // Register settings per phase: layers, input, hidden a, hidden b, output, rate
  int phase_cfg[8][6] = '{
    '{4, 8, 8, 8, 8, 4096},
    '{2, 1, 1, 1, 1, 0},
    '{3, 3, 5, 2, 4, 410},
    '{0, 0, 15, 0, 15, 8191},
    '{7, 15, 15, 15, 15, 1234},
    '{4, 2, 3, 1, 2, 100},
    '{3, 8, 8, 4, 8, 2000},
    '{4, 1, 1, 1, 1, 4096}
  };

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_WRITE;
    in_ch.position = '0;
    in_ch.value = '0;
    in_ch.train = 1'b0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    request_count = 0;
    seen_results = 0;
    out_hold = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Fill every weight, feature and target so no run touches an unwritten entry
    reg_write(REG_IN_W, 8);
    reg_write(REG_OUT_W, 8);
    no_idle = 1'b1;
    for (int i = 0; i < 256; i++) send_request(FN_WRITE, 8'(i), pick_value(), 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_request(FN_FEAT, 8'(i), pick_value(), 1'b0);
      send_request(FN_TGT, 8'(i), pick_value(), 1'b0);
    end
    no_idle = 1'b0;
    drain();
    reg_write(REG_IN_W, 2);
    reg_write(REG_OUT_W, 1);

    // Directed: field extremes, every function, ignored cases
    send_request(FN_READ, 8'd0, 16'sd0, 1'b0);
    send_request(FN_READ, 8'd255, 16'sd0, 1'b1);
    send_request(FN_WRITE, 8'd255, 16'sh7fff, 1'b1);
    send_request(FN_READ, 8'd255, 16'sh7fff, 1'b0);
    send_request(FN_WRITE, 8'd254, 16'sh8000, 1'b0);
    send_request(FN_READ, 8'd254, 16'sh8000, 1'b0);
    send_request(FN_FEAT, 8'd0, 16'sh7fff, 1'b0);
    send_request(FN_FEAT, 8'd1, 16'sh8000, 1'b0);
    send_request(FN_FEAT, 8'd200, 16'sh1234, 1'b0);
    send_request(FN_TGT, 8'd0, 16'sh8000, 1'b0);
    send_request(FN_TGT, 8'd255, 16'sh7fff, 1'b0);
    send_request(FN_RUN, 8'd0, 16'sd0, 1'b0);
    send_request(FN_RUN, 8'd255, 16'shffff, 1'b1);
    send_request(func_t'(3'd5), 8'd1, 16'sd1, 1'b1);
    send_request(func_t'(3'd6), 8'd2, 16'sd2, 1'b0);
    send_request(func_t'(3'd7), 8'd3, 16'sd3, 1'b1);
    send_request(FN_RUN, 8'd0, 16'sd0, 1'b1);
    send_request(FN_READ, 8'd0, 16'sd0, 1'b0);
    send_request(FN_FEAT, 8'd0, 16'sd4096, 1'b0);
    send_request(FN_FEAT, 8'd1, -16'sd2048, 1'b0);
    send_request(FN_RUN, 8'd0, 16'sd0, 1'b0);

    // Random phases over several register settings
    for (int p = 0; p < 8; p++) begin
      load_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3],
                  phase_cfg[p][4], phase_cfg[p][5]);
      no_idle = (p % 3 == 2);
      for (int n = 0; n < 7; n++) random_request();
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    // Wait for the last results, then the tail of the last training step
    while (pending != 0) @(negedge clk);
    repeat (3000) @(negedge clk);

    $display("Sent %0d requests over 8 register settings; checked %0d results.",
             request_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
